FILE: rtl/file_fingerprint_checksums_core_defines.svh
// Assertion macros shared by the fingerprint RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef FILE_FINGERPRINT_CHECKSUMS_CORE_DEFINES_SVH
`define FILE_FINGERPRINT_CHECKSUMS_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted
`define FFC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define FFC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FFC_ASSERT(label, clk, rst_n, prop, msg)
`define FFC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/ffc_pkg.sv
// Types, constants and the CRC byte step for the file fingerprint block.
// No dependencies; imported by ffc_marks and file_fingerprint_checksums_core.
package ffc_pkg;

    localparam logic [15:0] ADLER_MOD  = 16'd65521;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam int          BYTE_BITS  = 8;
    localparam int          LANE_COUNT = 4;

    // One input transfer: a file byte with its framing flags
    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 first_byte;
        logic                 last_byte;
    } ffc_in_t;

    // One result transfer: the four marks of a finished file
    typedef struct packed {
        logic [63:0] sum_mark;
        logic [31:0] xor_mark;
        logic [31:0] adler_mark;
        logic [31:0] crc_mark;
    } ffc_out_t;

    // Reflected CRC-32 over one byte, eight bit steps unrolled
    function automatic logic [31:0] crc_byte_step(input logic [31:0] crc,
                                                  input logic [BYTE_BITS-1:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int k = 0; k < BYTE_BITS; k++) begin
            if (r[0])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

endpackage

FILE: rtl/ffc_marks.sv
// Running mark registers (sum, lane XOR, Adler-32, CRC-32) and their update.
// Depends on ffc_pkg and the assertion macro header.
`include "file_fingerprint_checksums_core_defines.svh"

module ffc_marks
    import ffc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  ffc_in_t  item,
    output ffc_out_t marks
);

    logic [63:0] sum_reg,   sum_next,   sum_base;
    logic [31:0] xor_reg,   xor_next,   xor_base;
    logic [15:0] adler_a_reg, adler_a_next, adler_a_base;
    logic [15:0] adler_b_reg, adler_b_next, adler_b_base;
    logic [31:0] crc_reg,   crc_next,   crc_base;
    logic [1:0]  phase_reg, phase_next, phase_base;
    logic [16:0] a_sum;
    logic [16:0] b_sum;
    logic [31:0] lane_word;

    // Start values: initial marks on a first byte, else the running state
    always_comb
    begin
        if (item.first_byte)
        begin
            sum_base     = '0;
            xor_base     = '0;
            adler_a_base = 16'd1;
            adler_b_base = '0;
            crc_base     = CRC_INIT;
            phase_base   = '0;
        end
        else
        begin
            sum_base     = sum_reg;
            xor_base     = xor_reg;
            adler_a_base = adler_a_reg;
            adler_b_base = adler_b_reg;
            crc_base     = crc_reg;
            phase_base   = phase_reg;
        end
    end

    // Byte placed in its lane
    always_comb
    begin
        case (phase_base)
            2'd0:    lane_word = {24'd0, item.data_byte};
            2'd1:    lane_word = {16'd0, item.data_byte, 8'd0};
            2'd2:    lane_word = {8'd0, item.data_byte, 16'd0};
            2'd3:    lane_word = {item.data_byte, 24'd0};
            default: lane_word = '0;
        endcase
    end

    // Mark updates for one byte
    always_comb
    begin
        sum_next   = sum_base + {56'd0, item.data_byte};
        xor_next   = xor_base ^ lane_word;
        phase_next = phase_base + 2'd1;

        // Both sums stay below the modulus, so one conditional subtract does
        a_sum = {1'b0, adler_a_base} + {9'd0, item.data_byte};
        if (a_sum >= {1'b0, ADLER_MOD})
            a_sum = a_sum - {1'b0, ADLER_MOD};
        adler_a_next = a_sum[15:0];

        b_sum = {1'b0, adler_b_base} + {1'b0, adler_a_next};
        if (b_sum >= {1'b0, ADLER_MOD})
            b_sum = b_sum - {1'b0, ADLER_MOD};
        adler_b_next = b_sum[15:0];

        crc_next = crc_byte_step(crc_base, item.data_byte);
    end

    // Marks as they stand after this byte
    always_comb
    begin
        marks.sum_mark   = sum_next;
        marks.xor_mark   = xor_next;
        marks.adler_mark = {adler_b_next, adler_a_next};
        marks.crc_mark   = ~crc_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            xor_reg     <= '0;
            adler_a_reg <= 16'd1;
            adler_b_reg <= '0;
            crc_reg     <= CRC_INIT;
            phase_reg   <= '0;
        end
        else if (step)
        begin
            sum_reg     <= sum_next;
            xor_reg     <= xor_next;
            adler_a_reg <= adler_a_next;
            adler_b_reg <= adler_b_next;
            crc_reg     <= crc_next;
            phase_reg   <= phase_next;
        end
    end

    `FFC_ASSERT_ALWAYS(a_in_range_chk, clk, adler_a_reg < ADLER_MOD, "Adler sum A out of range")
    `FFC_ASSERT_ALWAYS(b_in_range_chk, clk, adler_b_reg < ADLER_MOD, "Adler sum B out of range")
    `FFC_ASSERT(first_sum_chk, clk, rst_n, step && item.first_byte |=> sum_reg == {56'd0, $past(item.data_byte)}, "sum not restarted by first byte")
    `FFC_ASSERT(first_phase_chk, clk, rst_n, step && item.first_byte |=> phase_reg == 2'd1, "lane phase not restarted by first byte")

endmodule

FILE: rtl/file_fingerprint_checksums_core.sv
// File fingerprint block: input register, mark update, result register.
// Depends on ffc_pkg, ffc_marks and the assertion macro header.
//
// Usage:
//   byte channel (byte_valid / byte_stall / byte_item) takes one file byte per
//   transfer with first_byte and last_byte flags. first_byte restarts all marks
//   before its byte; last_byte makes the block emit one result after its byte.
//   mark channel (mark_valid / mark_stall / mark_item) returns sum, lane XOR,
//   Adler-32 and CRC-32 of the file.
// Path: a last byte moves from the input register straight into the result
//   register when that register is free, and mark_valid rises as it lands.
// Throughput: one byte per cycle unless a last byte waits on a blocked
//   result; the update of all four marks is short combinational logic
//   between the input register and the mark registers.
// Stall: while a result waits under mark_stall, bytes that end no file still
//   flow; a last byte waits in the input register, and byte_stall rises only
//   when that register is full and cannot advance.
// Reset: rst_n clears both valid flags and sets marks to initial values
//   (sum 0, xor 0, Adler 1, CRC all ones before complement).
`include "file_fingerprint_checksums_core_defines.svh"

module file_fingerprint_checksums_core
    import ffc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_stall,
    input  ffc_in_t  byte_item,
    input  logic     mark_stall,
    output logic     mark_valid,
    output ffc_out_t mark_item
);

    logic     in_valid_reg;
    ffc_in_t  in_item_reg;
    logic     out_valid_reg;
    ffc_out_t out_item_reg;
    logic     out_free;
    logic     step;
    logic     in_take;
    ffc_out_t marks;

    // Handshake: the held byte advances unless it ends a file and the result is blocked
    assign out_free   = !out_valid_reg || !mark_stall;
    assign step       = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign byte_stall = in_valid_reg && !step;
    assign in_take    = byte_valid && !byte_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= byte_item;
    end

    ffc_marks u_marks (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .marks (marks)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && in_item_reg.last_byte)
            out_valid_reg <= 1'b1;
        else if (!mark_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && in_item_reg.last_byte)
            out_item_reg <= marks;
    end

    assign mark_valid = out_valid_reg;
    assign mark_item  = out_item_reg;

    `FFC_ASSERT(hold_in_chk, clk, rst_n, in_valid_reg && !step |=> in_valid_reg && $stable(in_item_reg), "held byte lost or changed")
    `FFC_ASSERT(no_extra_out_chk, clk, rst_n, step && !in_item_reg.last_byte && !(out_valid_reg && mark_stall) |=> !out_valid_reg, "result raised without a last byte")
    `FFC_ASSERT(empty_ready_chk, clk, rst_n, !in_valid_reg |-> !byte_stall, "stall with empty input register")

endmodule
